/* rtl/core/microwire_eeprom_word_emulator_macros.svh */
// Assertion macros used by the emulator's top-level RTL.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef MICROWIRE_EEPROM_WORD_EMULATOR_MACROS_SVH
`define MICROWIRE_EEPROM_WORD_EMULATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
`define MEW_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MEW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MEW_ASSERT_SAME(lbl, ante, cons, msg)
`define MEW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/core/mew_pkg.sv */
package mew_pkg;

    localparam int WORD_W     = 16;
    localparam int CMD_W      = 5;
    localparam int KIND_W     = 3;
    localparam int MASK_W     = 10;
    localparam int SHIFT_W    = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_KIND = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_MODE   = 1'd1;

    localparam logic [WORD_W-1:0] ERASED_WORD = 16'hFFFF;

    localparam logic [CMD_W-1:0] CMD_WDS      = 5'h10;
    localparam logic [CMD_W-1:0] CMD_WRAL     = 5'h11;
    localparam logic [CMD_W-1:0] CMD_ERAL     = 5'h12;
    localparam logic [CMD_W-1:0] CMD_WEN      = 5'h13;
    localparam logic [CMD_W-1:0] CMD_WRITE_LO = 5'h14;
    localparam logic [CMD_W-1:0] CMD_WRITE_HI = 5'h17;
    localparam logic [CMD_W-1:0] CMD_READ_LO  = 5'h18;
    localparam logic [CMD_W-1:0] CMD_READ_HI  = 5'h1B;
    localparam logic [CMD_W-1:0] CMD_ERASE_LO = 5'h1C;
    localparam logic [CMD_W-1:0] CMD_ERASE_HI = 5'h1F;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_FILL
    } state_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_READ,
        ACT_WRITE,
        ACT_FILL
    } action_t;

    typedef struct packed {
        logic load;
        logic apply;
        logic clear_step;
        logic fill_step;
        logic finish_blank;
        logic finish_read;
    } ctrl_cmd_t;

    typedef struct packed {
        action_t action;
        logic    clear_last;
        logic    fill_last;
    } dp_status_t;

    function automatic logic [MASK_W-1:0] kind_mask(input logic [KIND_W-1:0] kind);
        logic [MASK_W-1:0] m;
        unique case (kind)
            3'd1:    m = 10'h00F;
            3'd2:    m = 10'h03F;
            3'd3:    m = 10'h07F;
            3'd4:    m = 10'h0FF;
            3'd5:    m = 10'h1FF;
            3'd6:    m = 10'h3FF;
            default: m = 10'h000;
        endcase
        return m;
    endfunction

    function automatic logic [SHIFT_W-1:0] kind_shift(input logic [KIND_W-1:0] kind);
        logic [SHIFT_W-1:0] s;
        unique case (kind)
            3'd1, 3'd2: s = 4'd4;
            3'd3, 3'd4: s = 4'd6;
            3'd5, 3'd6: s = 4'd8;
            default:    s = 4'd0;
        endcase
        return s;
    endfunction

endpackage

/* rtl/core/microwire_eeprom_word_emulator.sv */
// After reset the store is erased in one pass over all STORE_WORDS words; busy stays high.
// A request is accepted when start is high and busy is low; done and its reply follow
// once the word is latched and decoded; a READ also passes ST_READ, and ERAL or the data
// word of WRAL passes ST_FILL, one store write per cycle through the single memory port.
// A new request is accepted in the cycle that shows the previous reply.
// Replies are shown for one cycle only; the receiver cannot stall them.
`include "microwire_eeprom_word_emulator_macros.svh"

module microwire_eeprom_word_emulator #(
    parameter int STORE_WORDS = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [mew_pkg::WORD_W-1:0]      bus_word,
    output logic [mew_pkg::WORD_W-1:0]      reply_word,
    output logic                            done,
    input  logic                            cfg_we,
    input  logic [mew_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mew_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mew_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    mew_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    mew_datapath #(
        .STORE_WORDS (STORE_WORDS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .bus_word   (bus_word),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .reply_word (reply_word),
        .done       (done)
    );

    // Each request is latched and then decoded before any reply, so replies never come back to back.
    `MEW_ASSERT_NEXT(a_done_spaced, done, !done, "two replies in consecutive cycles")
    `MEW_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "block idle after a request")
    `MEW_ASSERT_SAME(a_done_from_work, done, $past(busy), "reply without work in progress")
    `MEW_ASSERT_SAME(a_single_action, cmd.finish_read, !cmd.finish_blank && !cmd.fill_step,
                     "read reply mixed with another action")

endmodule

/* rtl/core/mew_ctrl.sv */
module mew_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  mew_pkg::dp_status_t status,
    output mew_pkg::ctrl_cmd_t  cmd,
    output logic                busy
);
    import mew_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (status.action)
                    ACT_READ: state_next = ST_READ;
                    ACT_FILL: state_next = ST_FILL;
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            ST_FILL:
            begin
                if (status.fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_DECODE:
            begin
                cmd.apply = 1'b1;
                // Reads and fills report from their own states.
                cmd.finish_blank = (status.action == ACT_NONE) ||
                                   (status.action == ACT_WRITE);
            end
            ST_READ:
            begin
                cmd.finish_read = 1'b1;
            end
            ST_FILL:
            begin
                cmd.fill_step    = 1'b1;
                cmd.finish_blank = status.fill_last;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

/* rtl/core/mew_datapath.sv */
module mew_datapath #(
    parameter int STORE_WORDS = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mew_pkg::ctrl_cmd_t                 cmd,
    output mew_pkg::dp_status_t                status,
    input  logic [mew_pkg::WORD_W-1:0]         bus_word,
    input  logic                               cfg_we,
    input  logic [mew_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mew_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic [mew_pkg::WORD_W-1:0]         reply_word,
    output logic                               done
);
    import mew_pkg::*;

    localparam int ADDR_W = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam logic [MASK_W:0]   STORE_LIM = (MASK_W + 1)'(STORE_WORDS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_WORDS - 1);

    logic [WORD_W-1:0] mem [STORE_WORDS];

    logic [KIND_W-1:0] kind_reg;
    logic              full_reg;
    logic              pend_valid_reg;
    logic [WORD_W-1:0] pend_cmd_reg;
    logic              wr_en_reg;
    logic [ADDR_W-1:0] cnt_reg;
    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] fill_val_reg;
    logic [WORD_W-1:0] rd_data_reg;
    logic [WORD_W-1:0] reply_reg;
    logic              done_reg;

    logic              pend_valid_next;
    logic [WORD_W-1:0] pend_cmd_next;
    logic              wr_en_next;

    logic [MASK_W-1:0]  mask;
    logic [SHIFT_W-1:0] shift;
    logic               may_write;
    logic [CMD_W-1:0]   op;
    logic [MASK_W-1:0]  dec_addr;
    logic               dec_in_range;
    logic [WORD_W-1:0]  dec_value;
    action_t            dec_action;
    logic [ADDR_W-1:0]  fill_top;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic [WORD_W-1:0]  mem_wdata;

    assign mask      = kind_mask(kind_reg);
    assign shift     = kind_shift(kind_reg);
    assign may_write = !full_reg || wr_en_reg;
    assign fill_top  = ({1'b0, mask} >= (STORE_LIM - 1'b1)) ? LAST_ADDR : mask[ADDR_W-1:0];

    // Decode of the latched word against the pending command and the write enable.
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_cmd_next   = pend_cmd_reg;
        wr_en_next      = wr_en_reg;
        dec_action      = ACT_NONE;
        dec_value       = ERASED_WORD;
        if (pend_valid_reg)
        begin
            op        = CMD_W'(pend_cmd_reg >> shift);
            dec_addr  = pend_cmd_reg[MASK_W-1:0] & mask;
            dec_value = word_reg;
        end
        else
        begin
            op       = CMD_W'(word_reg >> shift);
            dec_addr = word_reg[MASK_W-1:0] & mask;
        end
        dec_in_range = ({1'b0, dec_addr} < STORE_LIM);

        if (pend_valid_reg)
        begin
            pend_valid_next = 1'b0;
            pend_cmd_next   = '0;
            if (may_write)
            begin
                if (op == CMD_WRAL)
                begin
                    dec_action = ACT_FILL;
                end
                else if (dec_in_range)
                begin
                    dec_action = ACT_WRITE;
                end
            end
        end
        else
        begin
            case (op) inside
                CMD_WDS:
                begin
                    if (full_reg)
                    begin
                        wr_en_next = 1'b0;
                    end
                end
                CMD_ERAL:
                begin
                    if (may_write)
                    begin
                        dec_action = ACT_FILL;
                    end
                end
                CMD_WEN:
                begin
                    if (full_reg)
                    begin
                        wr_en_next = 1'b1;
                    end
                end
                CMD_WRAL, [CMD_WRITE_LO:CMD_WRITE_HI]:
                begin
                    pend_valid_next = 1'b1;
                    pend_cmd_next   = word_reg;
                end
                [CMD_READ_LO:CMD_READ_HI]:
                begin
                    if (full_reg && dec_in_range)
                    begin
                        dec_action = ACT_READ;
                    end
                end
                [CMD_ERASE_LO:CMD_ERASE_HI]:
                begin
                    if (may_write && dec_in_range)
                    begin
                        dec_action = ACT_WRITE;
                    end
                end
                default:
                begin
                    dec_action = ACT_NONE;
                end
            endcase
        end
    end

    assign status.action     = dec_action;
    assign status.clear_last = (cnt_reg == LAST_ADDR);
    assign status.fill_last  = (cnt_reg == fill_top);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg       <= '0;
            full_reg       <= 1'b1;
            pend_valid_reg <= 1'b0;
            pend_cmd_reg   <= '0;
            wr_en_reg      <= 1'b0;
            cnt_reg        <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish_blank || cmd.finish_read;
            if (cmd.apply)
            begin
                pend_valid_reg <= pend_valid_next;
                pend_cmd_reg   <= pend_cmd_next;
                wr_en_reg      <= wr_en_next;
            end
            if (cmd.apply && dec_action == ACT_FILL)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.clear_step || cmd.fill_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_DEVICE_KIND:
                    begin
                        kind_reg       <= cfg_data[KIND_W-1:0];
                        pend_valid_reg <= 1'b0;
                        pend_cmd_reg   <= '0;
                        wr_en_reg      <= 1'b0;
                    end
                    REG_FULL_MODE:
                    begin
                        full_reg <= cfg_data[0];
                    end
                    default:
                    begin
                        full_reg <= full_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            word_reg <= bus_word;
        end
        if (cmd.apply && dec_action == ACT_FILL)
        begin
            fill_val_reg <= dec_value;
        end
        if (cmd.finish_read)
        begin
            reply_reg <= rd_data_reg;
        end
        else if (cmd.finish_blank)
        begin
            reply_reg <= ERASED_WORD;
        end
    end

    assign mem_we = cmd.clear_step || cmd.fill_step || (cmd.apply && dec_action == ACT_WRITE);
    assign mem_addr = (cmd.clear_step || cmd.fill_step) ? cnt_reg : dec_addr[ADDR_W-1:0];
    assign mem_wdata = cmd.clear_step ? ERASED_WORD :
                       cmd.fill_step  ? fill_val_reg : dec_value;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (cmd.apply && dec_action == ACT_READ)
        begin
            rd_data_reg <= mem[dec_addr[ADDR_W-1:0]];
        end
    end

    assign reply_word = reply_reg;
    assign done       = done_reg;

endmodule

/* dv/tb_microwire_eeprom_word_emulator.sv */
`timescale 1ns / 1ps

module tb_microwire_eeprom_word_emulator;
    import mew_pkg::*;

    localparam int DEPTH = 1024;

    typedef struct {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        logic [WORD_W-1:0]     word;
        logic                  pinned;
        logic [WORD_W-1:0]     reply;
    } step_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [WORD_W-1:0]     bus_word;
    logic [WORD_W-1:0]     reply_word;
    logic                  done;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Hand-typed reply for a directed request, travelling alongside start.
    logic                  pin_valid;
    logic [WORD_W-1:0]     pin_reply;

    // Mirror of the emulated device.
    logic [WORD_W-1:0]     eeprom_image [DEPTH];
    logic [KIND_W-1:0]     prom_kind;
    logic                  prom_full;
    logic                  wr_armed;
    logic                  held_valid;
    logic [WORD_W-1:0]     held_cmd;

    logic [WORD_W-1:0]     replies_due [$];
    step_row_t             directed_rows [$];
    logic [9:0]            hot_addr [8];

    int errors;
    int accepted_total;
    int n_reads;
    int n_data;
    int n_fills;
    int burst_left;
    logic gaps_on;

    microwire_eeprom_word_emulator uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .bus_word   (bus_word),
        .reply_word (reply_word),
        .done       (done),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [9:0] addr_mask(input logic [KIND_W-1:0] kind);
        case (kind)
            3'd1:    return 10'h00F;
            3'd2:    return 10'h03F;
            3'd3:    return 10'h07F;
            3'd4:    return 10'h0FF;
            3'd5:    return 10'h1FF;
            3'd6:    return 10'h3FF;
            default: return 10'h000;
        endcase
    endfunction

    function automatic int cmd_shift(input logic [KIND_W-1:0] kind);
        case (kind)
            3'd1, 3'd2: return 4;
            3'd3, 3'd4: return 6;
            3'd5, 3'd6: return 8;
            default:    return 0;
        endcase
    endfunction

    function automatic void fill_store(input logic [WORD_W-1:0] v);
        int top;
        top = int'(addr_mask(prom_kind));
        n_fills++;
        for (int i = 0; i <= top; i++)
            eeprom_image[i] = v;
    endfunction

    function automatic void eeprom_reset();
        for (int i = 0; i < DEPTH; i++)
            eeprom_image[i] = ERASED_WORD;
        prom_kind  = '0;
        prom_full  = 1'b1;
        wr_armed   = 1'b0;
        held_valid = 1'b0;
        held_cmd   = '0;
    endfunction

    function automatic void eeprom_config(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        if (idx == REG_DEVICE_KIND) begin
            prom_kind  = val;
            held_valid = 1'b0;
            held_cmd   = '0;
            wr_armed   = 1'b0;
        end
        else if (idx == REG_FULL_MODE) begin
            prom_full = val[0];
        end
    endfunction

    // Applies one request to the mirror and returns the reply it should produce.
    function automatic logic [WORD_W-1:0] eeprom_answer(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] reply;
        logic [9:0]        m;
        int                sh;
        logic [CMD_W-1:0]  code;
        logic              open;
        reply = ERASED_WORD;
        m     = addr_mask(prom_kind);
        sh    = cmd_shift(prom_kind);
        open  = !prom_full || wr_armed;
        if (held_valid) begin
            code = held_cmd[sh +: 5];
            n_data++;
            if (open) begin
                if (code == CMD_WRAL)
                    fill_store(w);
                else
                    eeprom_image[held_cmd[9:0] & m] = w;
            end
            held_valid = 1'b0;
            held_cmd   = '0;
            return reply;
        end
        code = w[sh +: 5];
        if (code == CMD_WDS) begin
            if (prom_full)
                wr_armed = 1'b0;
        end
        else if (code == CMD_ERAL) begin
            if (open)
                fill_store(ERASED_WORD);
        end
        else if (code == CMD_WEN) begin
            if (prom_full)
                wr_armed = 1'b1;
        end
        else if (code == CMD_WRAL || (code >= CMD_WRITE_LO && code <= CMD_WRITE_HI)) begin
            held_valid = 1'b1;
            held_cmd   = w;
        end
        else if (code >= CMD_READ_LO && code <= CMD_READ_HI) begin
            if (prom_full) begin
                reply = eeprom_image[w[9:0] & m];
                n_reads++;
            end
        end
        else if (code >= CMD_ERASE_LO) begin
            if (open)
                eeprom_image[w[9:0] & m] = ERASED_WORD;
        end
        return reply;
    endfunction

    // Builds a command word for the current kind. For the grouped commands the two
    // lowest command bits may overlap the address, so they are left to the address.
    function automatic logic [WORD_W-1:0] cmd_word(input logic [CMD_W-1:0] code,
                                                   input logic [9:0] addr);
        logic [WORD_W-1:0] w;
        logic [9:0]        m;
        int                sh;
        w  = WORD_W'($urandom);
        m  = addr_mask(prom_kind);
        sh = cmd_shift(prom_kind);
        w  = (w & ~{6'd0, m}) | {6'd0, addr & m};
        if (code >= CMD_WRITE_LO)
            w[sh + 2 +: 3] = code[4:2];
        else
            w[sh +: 5] = code;
        return w;
    endfunction

    function automatic logic [9:0] pick_addr();
        logic [9:0] a;
        if ($urandom_range(0, 1) == 0)
            a = hot_addr[3'($urandom_range(0, 7))];
        else
            a = 10'($urandom);
        return a;
    endfunction

    function automatic logic [WORD_W-1:0] pick_data();
        logic [WORD_W-1:0] d;
        case ($urandom_range(0, 7))
            0:       d = 16'h0000;
            1:       d = 16'hFFFF;
            default: d = WORD_W'($urandom);
        endcase
        return d;
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] want,
                                   input logic [WORD_W-1:0] got);
        errors++;
        if (errors <= 10)
            $display("MISMATCH %s: expected %04h, got %04h at %0t", what, want, got, $realtime);
    endtask

    // Scoreboard: replies are compared first, then a newly accepted request is predicted.
    always @(posedge clk) begin : watch
        logic [WORD_W-1:0] want;
        if (rst_n) begin
            if (done) begin
                if (replies_due.size() == 0) begin
                    report_mismatch("unexpected reply", ERASED_WORD, reply_word);
                end
                else begin
                    want = replies_due.pop_front();
                    if (reply_word !== want)
                        report_mismatch("reply_word", want, reply_word);
                end
            end
            if (start && !busy) begin
                want = eeprom_answer(bus_word);
                if (pin_valid)
                    want = pin_reply;
                replies_due.push_back(want);
                accepted_total++;
            end
            if (cfg_we)
                eeprom_config(cfg_index, cfg_data);
        end
    end

    task automatic issue(input logic [WORD_W-1:0] w, input logic pin,
                         input logic [WORD_W-1:0] pinned);
        int gap;
        if (gaps_on) begin
            if (burst_left == 0) begin
                if ($urandom_range(0, 9) == 0)
                    gap = $urandom_range(8, 30);
                else
                    gap = $urandom_range(1, 5);
                start <= 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        start     <= 1'b1;
        bus_word  <= w;
        pin_valid <= pin;
        pin_reply <= pinned;
        do @(posedge clk); while (busy);
    endtask

    task automatic send(input logic [WORD_W-1:0] w);
        issue(w, 1'b0, ERASED_WORD);
    endtask

    // Holds the sender off until every outstanding reply has arrived.
    task automatic settle();
        start <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (replies_due.size() != 0 || busy);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic add_req(input logic [WORD_W-1:0] w, input logic pin,
                           input logic [WORD_W-1:0] reply);
        step_row_t row;
        row = '{1'b0, '0, '0, w, pin, reply};
        directed_rows.push_back(row);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        step_row_t row;
        row = '{1'b1, idx, val, '0, 1'b0, '0};
        directed_rows.push_back(row);
    endtask

    initial begin : timeout
        #100_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        int phase;
        int count;
        int pick;
        int guard;
        logic [KIND_W-1:0] kind;
        logic              full;
        clk       = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        bus_word  = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        pin_valid = 1'b0;
        pin_reply = '0;
        errors = 0;
        accepted_total = 0;
        n_reads = 0;
        n_data = 0;
        n_fills = 0;
        burst_left = 0;
        gaps_on = 1'b1;
        eeprom_reset();
        hot_addr[0] = 10'h000;
        hot_addr[1] = 10'h3FF;
        for (int i = 2; i < 8; i++)
            hot_addr[i] = 10'($urandom);

        // Directed table. Kind 0 after reset: command in the low five bits, one word.
        add_req(16'hFFFF, 1'b1, ERASED_WORD);       // erase while writes are disabled
        add_req(16'h0018, 1'b1, ERASED_WORD);       // store reads erased after reset
        add_cfg(REG_DEVICE_KIND, 3'd6);
        add_req(16'h17FF, 1'b1, ERASED_WORD);       // write to the top address, not enabled
        add_req(16'h1234, 1'b1, ERASED_WORD);
        add_req(16'h1300, 1'b1, ERASED_WORD);       // write enable
        add_req(16'h17FF, 1'b1, ERASED_WORD);
        add_req(16'h0000, 1'b1, ERASED_WORD);
        add_req(16'h1BFF, 1'b1, 16'h0000);
        add_req(16'h1400, 1'b0, '0);
        add_req(16'hA5C3, 1'b0, '0);
        add_req(16'h1800, 1'b0, '0);
        add_req(16'h1C00, 1'b0, '0);                // erase a single word
        add_req(16'h1800, 1'b1, ERASED_WORD);
        add_req(16'h1100, 1'b0, '0);                // write all, then its data word
        add_req(16'h5A5A, 1'b1, ERASED_WORD);
        add_req(16'h1A55, 1'b1, 16'h5A5A);
        add_req(16'h1000, 1'b0, '0);                // disable, so erase-all is refused
        add_req(16'h1200, 1'b0, '0);
        add_req(16'h1BFF, 1'b1, 16'h5A5A);
        add_req(16'h1300, 1'b0, '0);
        add_req(16'h1200, 1'b0, '0);
        add_req(16'h1800, 1'b1, ERASED_WORD);
        add_cfg(REG_FULL_MODE, 3'd0);
        add_req(16'h1800, 1'b1, ERASED_WORD);       // reads answer erased outside full mode
        add_cfg(REG_DEVICE_KIND, 3'd7);             // unknown kind behaves as kind 0
        add_req(16'h0014, 1'b0, '0);
        add_req(16'h1357, 1'b0, '0);
        add_cfg(REG_FULL_MODE, 3'd1);
        add_req(16'h0018, 1'b1, 16'h1357);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        settle();

        foreach (directed_rows[r]) begin
            if (directed_rows[r].is_cfg) begin
                settle();
                write_reg(directed_rows[r].idx, directed_rows[r].val);
            end
            else begin
                issue(directed_rows[r].word, directed_rows[r].pinned, directed_rows[r].reply);
            end
        end

        // Random phases: every kind, each once with and once without full mode.
        for (phase = 0; phase < 16; phase++) begin
            kind = KIND_W'((phase * 5 + 1) % 8);
            full = (phase < 8) ? phase[0] : !phase[0];
            settle();
            if ($urandom_range(0, 1) == 0) begin
                write_reg(REG_DEVICE_KIND, kind);
                write_reg(REG_FULL_MODE, {2'b00, full});
            end
            else begin
                write_reg(REG_FULL_MODE, {2'b00, full});
                write_reg(REG_DEVICE_KIND, kind);
            end
            gaps_on = (phase % 4 != 3);
            count = 0;
            while (count < 70) begin
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    send(cmd_word(CMD_WEN, pick_addr()));
                    count++;
                end
                else if (pick < 15) begin
                    send(cmd_word(CMD_WDS, pick_addr()));
                    count++;
                end
                else if (pick < 40) begin
                    send(cmd_word(CMD_WRITE_LO, pick_addr()));
                    send(pick_data());
                    count += 2;
                end
                else if (pick < 65) begin
                    send(cmd_word(CMD_READ_LO, pick_addr()));
                    count++;
                end
                else if (pick < 75) begin
                    send(cmd_word(CMD_ERASE_LO, pick_addr()));
                    count++;
                end
                else if (pick < 78) begin
                    send(cmd_word(CMD_WRAL, pick_addr()));
                    send(pick_data());
                    count += 2;
                end
                else if (pick < 80) begin
                    send(cmd_word(CMD_ERAL, pick_addr()));
                    count++;
                end
                else if (pick < 90) begin
                    send(WORD_W'($urandom));
                    count++;
                end
                else if (pick < 95) begin
                    // A write whose data word never comes: the next command is taken as data.
                    send(cmd_word(CMD_WRITE_LO, pick_addr()));
                    count++;
                end
                else begin
                    settle();
                end
            end
        end

        start <= 1'b0;
        guard = 0;
        while ((replies_due.size() != 0 || busy) && guard < 5000) begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        if (replies_due.size() != 0) begin
            errors++;
            $display("%0d replies never arrived", replies_due.size());
        end

        $display("Ran %0d requests: a directed table, then 16 kind and mode settings.",
                 accepted_total);
        $display("Seen %0d reads in full mode, %0d data words, %0d whole-store fills.",
                 n_reads, n_data, n_fills);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
